// ===== rtl/core/tce_pkg.sv =====
// Shared types and constants for the telemetry CBOR encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tce_pkg;

    localparam logic [15:0] CAP_RESET     = 16'd512;
    localparam int          MAX_PAIRS_DEF = 23;

    // one input word as held in the input register
    typedef struct packed {
        logic        mode;
        logic        has_ident;
        logic        has_timestamp;
        logic        has_voltage;
        logic        has_current;
        logic [7:0]  pair_count;
        logic [15:0] ident;
        logic [31:0] timestamp;
        logic [31:0] voltage_bits;
        logic [31:0] current_bits;
        logic [31:0] freq_bits;
        logic [31:0] amp_bits;
    } t_item;

    // one output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       overflow;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/tce_inreg.sv =====
// Input holding register of the telemetry CBOR encoder.
// Depends on tce_pkg for the item type.
`default_nettype none

module tce_inreg (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  tce_pkg::t_item  i_item,
    input  wire             i_take,
    output logic            o_valid,
    output tce_pkg::t_item  o_item
);
    import tce_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tce_seq.sv =====
// Telemetry CBOR encoder byte sequencer; depends on tce_pkg. Walks one
// item's segments, one byte per cycle unless stalled; keeps packet state.
`default_nettype none

module tce_seq #(
    parameter int MAX_PAIRS = tce_pkg::MAX_PAIRS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  tce_pkg::t_item    i_item,
    input  wire               i_out_free,
    input  wire  [15:0]       i_capacity,
    output logic              o_take,
    output logic              o_push,
    output tce_pkg::t_result  o_res
);
    import tce_pkg::*;

    localparam int PW = $clog2(MAX_PAIRS + 1);

    localparam logic [2:0] SEG_MAP  = 3'd0;
    localparam logic [2:0] SEG_ID   = 3'd1;
    localparam logic [2:0] SEG_TS   = 3'd2;
    localparam logic [2:0] SEG_V    = 3'd3;
    localparam logic [2:0] SEG_I    = 3'd4;
    localparam logic [2:0] SEG_FFT  = 3'd5;
    localparam logic [2:0] SEG_PAIR = 3'd6;
    localparam logic [2:0] SEG_NONE = 3'd7;

    localparam logic [7:0] MAP_HDR  = 8'hA0;
    localparam logic [7:0] TXT1     = 8'h61;
    localparam logic [7:0] TXT2     = 8'h62;
    localparam logic [7:0] TXT3     = 8'h63;
    localparam logic [7:0] UINT16   = 8'h19;
    localparam logic [7:0] UINT32   = 8'h1A;
    localparam logic [7:0] FLOAT32  = 8'hFA;
    localparam logic [7:0] ARR_HDR  = 8'h80;
    localparam logic [7:0] ARR2     = 8'h82;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_F     = 8'h66;

    logic          r_active;
    logic [2:0]    r_seg;
    logic [3:0]    r_off;
    logic [15:0]   r_byte_count;
    logic [PW-1:0] r_pairs_left;
    logic          r_aborted;
    logic          r_final;

    logic          n_active;
    logic [2:0]    n_seg;
    logic [3:0]    n_off;
    logic [15:0]   n_byte_count;
    logic [PW-1:0] n_pairs_left;
    logic          n_aborted;
    logic          n_final;

    logic          is_hdr;
    logic          start;
    logic          drop;
    logic          work;
    logic          over;
    logic [PW-1:0] cnt;
    logic [2:0]    keys;
    logic [5:1]    pres;
    logic [2:0]    cur_seg;
    logic [3:0]    cur_off;
    logic [3:0]    seg_last;
    logic          seg_end;
    logic [2:0]    nxt;
    logic          item_end;
    logic [15:0]   cnt_eff;
    logic          final_eff;
    logic [7:0]    cur_byte;
    logic [3:0]    rel;

    function automatic logic [7:0] wbyte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            2'd2:    b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

    always_comb begin
        is_hdr  = !i_item.mode;
        start   = i_valid && !r_active;
        drop    = start && !is_hdr && (r_aborted || (r_pairs_left == '0));
        work    = i_valid && !drop && i_out_free;

        // clamp the pair count
        if (i_item.pair_count > 8'(MAX_PAIRS)) begin
            cnt = PW'(MAX_PAIRS);
        end else begin
            cnt = i_item.pair_count[PW-1:0];
        end

        pres = {(cnt != '0), i_item.has_current, i_item.has_voltage,
                i_item.has_timestamp, i_item.has_ident};
        keys = {2'b0, pres[1]} + {2'b0, pres[2]} + {2'b0, pres[3]}
             + {2'b0, pres[4]} + {2'b0, pres[5]};

        cur_seg   = r_active ? r_seg : (is_hdr ? SEG_MAP : SEG_PAIR);
        cur_off   = r_active ? r_off : 4'd0;
        cnt_eff   = (!r_active && is_hdr) ? 16'd0 : r_byte_count;
        final_eff = r_active ? r_final
                             : (is_hdr ? (cnt == '0) : (r_pairs_left == PW'(1)));

        case (cur_seg)
            SEG_MAP:  seg_last = 4'd0;
            SEG_ID:   seg_last = 4'd5;
            SEG_FFT:  seg_last = 4'd4;
            SEG_PAIR: seg_last = 4'd10;
            default:  seg_last = 4'd6;
        endcase
        seg_end = (cur_off == seg_last);

        // lowest present segment after the current one
        nxt = SEG_NONE;
        for (int k = 5; k >= 1; k--) begin
            if (pres[k] && (3'(k) > cur_seg)) begin
                nxt = 3'(k);
            end
        end
        item_end = seg_end && (nxt == SEG_NONE);

        over = (cnt_eff >= i_capacity);

        // byte at the current segment and offset
        rel = 4'd0;
        case (cur_seg)
            SEG_MAP: begin
                cur_byte = MAP_HDR | {5'b0, keys};
            end
            SEG_ID: begin
                case (cur_off)
                    4'd0:    cur_byte = TXT2;
                    4'd1:    cur_byte = CH_I;
                    4'd2:    cur_byte = CH_D;
                    4'd3:    cur_byte = UINT16;
                    4'd4:    cur_byte = i_item.ident[15:8];
                    default: cur_byte = i_item.ident[7:0];
                endcase
            end
            SEG_TS: begin
                rel = 4'd6 - cur_off;
                case (cur_off)
                    4'd0:    cur_byte = TXT1;
                    4'd1:    cur_byte = CH_T;
                    4'd2:    cur_byte = UINT32;
                    default: cur_byte = wbyte(i_item.timestamp, rel[1:0]);
                endcase
            end
            SEG_V: begin
                rel = 4'd6 - cur_off;
                case (cur_off)
                    4'd0:    cur_byte = TXT1;
                    4'd1:    cur_byte = CH_V;
                    4'd2:    cur_byte = FLOAT32;
                    default: cur_byte = wbyte(i_item.voltage_bits, rel[1:0]);
                endcase
            end
            SEG_I: begin
                rel = 4'd6 - cur_off;
                case (cur_off)
                    4'd0:    cur_byte = TXT1;
                    4'd1:    cur_byte = CH_I;
                    4'd2:    cur_byte = FLOAT32;
                    default: cur_byte = wbyte(i_item.current_bits, rel[1:0]);
                endcase
            end
            SEG_FFT: begin
                case (cur_off)
                    4'd0:    cur_byte = TXT3;
                    4'd1:    cur_byte = CH_F;
                    4'd2:    cur_byte = CH_F;
                    4'd3:    cur_byte = CH_T;
                    default: cur_byte = ARR_HDR | 8'(cnt);
                endcase
            end
            default: begin
                if (cur_off <= 4'd5) begin
                    rel = 4'd5 - cur_off;
                end else begin
                    rel = 4'd10 - cur_off;
                end
                case (cur_off)
                    4'd0:                      cur_byte = ARR2;
                    4'd1, 4'd6:                cur_byte = FLOAT32;
                    4'd2, 4'd3, 4'd4, 4'd5:    cur_byte = wbyte(i_item.freq_bits, rel[1:0]);
                    default:                   cur_byte = wbyte(i_item.amp_bits, rel[1:0]);
                endcase
            end
        endcase

        o_push = work;
        o_take = drop || (work && (over || item_end));
        if (over) begin
            o_res = '{out_byte: 8'd0, last: 1'b1, overflow: 1'b1};
        end else begin
            o_res = '{out_byte: cur_byte, last: final_eff && item_end, overflow: 1'b0};
        end
    end

    always_comb begin
        n_active     = r_active;
        n_seg        = r_seg;
        n_off        = r_off;
        n_byte_count = r_byte_count;
        n_pairs_left = r_pairs_left;
        n_aborted    = r_aborted;
        n_final      = r_final;
        if (work) begin
            if (start) begin
                n_final = final_eff;
                if (is_hdr) begin
                    n_pairs_left = cnt;
                    n_aborted    = 1'b0;
                end else begin
                    n_pairs_left = r_pairs_left - PW'(1);
                end
            end
            if (over) begin
                n_byte_count = cnt_eff;
                n_aborted    = 1'b1;
                n_pairs_left = '0;
                n_active     = 1'b0;
            end else begin
                n_byte_count = cnt_eff + 16'd1;
                n_active     = !item_end;
                if (seg_end) begin
                    n_seg = nxt;
                    n_off = 4'd0;
                end else begin
                    n_seg = cur_seg;
                    n_off = cur_off + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_seg        <= SEG_MAP;
            r_off        <= 4'd0;
            r_byte_count <= 16'd0;
            r_pairs_left <= '0;
            r_aborted    <= 1'b0;
            r_final      <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_seg        <= n_seg;
            r_off        <= n_off;
            r_byte_count <= n_byte_count;
            r_pairs_left <= n_pairs_left;
            r_aborted    <= n_aborted;
            r_final      <= n_final;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tce_outreg.sv =====
// Output register of the telemetry CBOR encoder.
// Depends on tce_pkg for the result type.
`default_nettype none

module tce_outreg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  tce_pkg::t_result  i_res,
    output logic              o_free,
    output logic              o_valid,
    input  wire               i_stall,
    output tce_pkg::t_result  o_res
);
    import tce_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/telemetry_cbor_encoder_unit.sv =====
// Top level of the telemetry CBOR encoder: input register, byte sequencer,
// output register and the capacity register. Depends on tce_pkg and all tce_ modules.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one word is a header record
//    (i_mode 0) or one spectrum pair (i_mode 1). A word is taken at a clock
//    edge with valid high and stall low.
//  - Output channel (o_out_valid / i_out_stall): one word is one CBOR byte
//    with its last and overflow marks, held steady while stalled.
//  - Config: i_cfg_we writes i_cfg_data into the packet capacity in bytes.
//    Write only while the block is idle.
//  - Path: input register, combinational sequencer, then output register.
//  - Throughput: one byte per cycle while the output is not stalled; the
//    byte sequencer is the limit. A pair word gives at most 11 bytes and a
//    header word 1 to 33. A surplus pair word is dropped without a byte. The
//    next word is taken on the cycle the final byte enters the output register.
//  - Overflow: when a byte would pass the capacity, drop the rest of the
//    word, emit one byte 0 with last and overflow set, and drop later pairs
//    until the next header.
//  - Reset: clears both registers' valid flags, the packet state, and sets
//    the capacity to 512 bytes.
//  - Stall: the output register holds its word; the sequencer freezes and
//    the input register fills, then raises o_in_stall.
`default_nettype none

module telemetry_cbor_encoder_unit #(
    parameter int MAX_PAIRS = tce_pkg::MAX_PAIRS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_data,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_mode,
    input  wire         i_has_ident,
    input  wire         i_has_timestamp,
    input  wire         i_has_voltage,
    input  wire         i_has_current,
    input  wire  [7:0]  i_pair_count,
    input  wire  [15:0] i_ident,
    input  wire  [31:0] i_timestamp,
    input  wire  [31:0] i_voltage_bits,
    input  wire  [31:0] i_current_bits,
    input  wire  [31:0] i_freq_bits,
    input  wire  [31:0] i_amp_bits,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_overflow
);
    import tce_pkg::*;

    logic [15:0] r_capacity;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    take;
    logic    push;
    logic    out_free;
    t_result seq_res;
    t_result out_res;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    assign in_item = '{
        mode:          i_mode,
        has_ident:     i_has_ident,
        has_timestamp: i_has_timestamp,
        has_voltage:   i_has_voltage,
        has_current:   i_has_current,
        pair_count:    i_pair_count,
        ident:         i_ident,
        timestamp:     i_timestamp,
        voltage_bits:  i_voltage_bits,
        current_bits:  i_current_bits,
        freq_bits:     i_freq_bits,
        amp_bits:      i_amp_bits
    };

    tce_inreg u_inreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // walk the held word one byte per cycle while the output is free
    tce_seq #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_item     (held_item),
        .i_out_free (out_free),
        .i_capacity (r_capacity),
        .o_take     (take),
        .o_push     (push),
        .o_res      (seq_res)
    );

    tce_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (seq_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_out_byte = out_res.out_byte;
    assign o_last     = out_res.last;
    assign o_overflow = out_res.overflow;

endmodule

`default_nettype wire
